@@ rtl/jsesc_pkg.sv @@
// Shared types, constants and byte classification functions for the JSON string escaper.
package jsesc_pkg;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_U         = 8'h75;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef enum logic [2:0] {
		HK_EMPTY,
		HK_SINGLE,
		HK_HOLD,
		HK_HEX,
		HK_PASS
	} head_kind_t;

	typedef struct packed {
		logic load;
		logic put_open;
		logic put_close;
		logic put_unit;
	} dp_cmd_t;

	typedef struct packed {
		head_kind_t kind;
		logic       at_end;
		logic       out_free;
	} dp_status_t;

	function automatic logic [2:0] seq_len(input logic [7:0] a);
		logic [2:0] n;
		n = 3'd0;
		if (a < 8'h80) begin
			n = 3'd1;
		end else if (a >= 8'hc2 && a <= 8'hdf) begin
			n = 3'd2;
		end else if (a >= 8'he0 && a <= 8'hef) begin
			n = 3'd3;
		end else if (a >= 8'hf0 && a <= 8'hf4) begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hbf;
		case (lead)
			8'he0: lo = 8'ha0;
			8'hed: hi = 8'h9f;
			8'hf0: lo = 8'h90;
			8'hf4: hi = 8'h8f;
			default: ;
		endcase
		return (b >= lo) && (b <= hi);
	endfunction

	function automatic logic cont_ok(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = 8'h30 + {4'd0, nib};
		end else begin
			d = 8'h57 + {4'd0, nib};
		end
		return d;
	endfunction

	function automatic logic [7:0] esc_char(input logic [7:0] b);
		logic [7:0] e;
		case (b)
			8'h22: e = 8'h22;
			8'h5c: e = 8'h5c;
			8'h0a: e = 8'h6e;
			8'h0d: e = 8'h72;
			8'h09: e = 8'h74;
			8'h08: e = 8'h62;
			8'h0c: e = 8'h66;
			default: e = 8'h00;
		endcase
		return e;
	endfunction

endpackage

@@ rtl/jsesc_dp.sv @@
// Datapath: byte buffer, head decoder, escape sequencer and output register.
module jsesc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jsesc_pkg::dp_cmd_t    cmd,
	output jsesc_pkg::dp_status_t status,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  out_last
);
	import jsesc_pkg::*;

	logic [7:0] buf_q [4];
	logic [2:0] cnt_q;
	logic [2:0] idx_q;
	logic       last_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic [7:0] head;
	logic [2:0] len;
	logic       bad;
	logic       incomplete;
	head_kind_t kind;
	logic [7:0] esc;
	logic       hex_form;
	logic       esc_form;
	logic [2:0] unit_n;
	logic [7:0] unit_byte;
	logic       unit_last;
	logic [2:0] use_n;
	logic [7:0] buf_sh [4];
	logic       out_free;

	always_comb begin
		head = buf_q[0];
		len = seq_len(head);
		bad = (len == 3'd0)
			|| (cnt_q > 3'd1 && len > 3'd1 && !second_ok(head, buf_q[1]))
			|| (cnt_q > 3'd2 && len > 3'd2 && !cont_ok(buf_q[2]))
			|| (cnt_q > 3'd3 && len > 3'd3 && !cont_ok(buf_q[3]));
		incomplete = !bad && (cnt_q < len);
		if (cnt_q == 3'd0) begin
			kind = HK_EMPTY;
		end else if (len == 3'd1) begin
			kind = HK_SINGLE;
		end else if (incomplete && !last_q) begin
			kind = HK_HOLD;
		end else if (bad || incomplete) begin
			kind = HK_HEX;
		end else begin
			kind = HK_PASS;
		end
	end

	always_comb begin
		esc = esc_char(head);
		esc_form = (kind == HK_SINGLE) && (esc != 8'h00);
		hex_form = (kind == HK_HEX)
			|| ((kind == HK_SINGLE) && (esc == 8'h00) && (head < CH_SPACE));
		unit_n = 3'd1;
		unit_byte = head;
		if (hex_form) begin
			unit_n = 3'd6;
			case (idx_q)
				3'd0: unit_byte = CH_BACKSLASH;
				3'd1: unit_byte = CH_U;
				3'd2: unit_byte = CH_ZERO;
				3'd3: unit_byte = CH_ZERO;
				3'd4: unit_byte = hex_digit(head[7:4]);
				default: unit_byte = hex_digit(head[3:0]);
			endcase
		end else if (esc_form) begin
			unit_n = 3'd2;
			unit_byte = (idx_q == 3'd0) ? CH_BACKSLASH : esc;
		end else if (kind == HK_PASS) begin
			unit_n = len;
			unit_byte = buf_q[idx_q[1:0]];
		end
		unit_last = (idx_q == unit_n - 3'd1);
		use_n = (kind == HK_PASS) ? len : 3'd1;
	end

	always_comb begin
		logic [2:0] j;
		j = 3'd0;
		for (int i = 0; i < 4; i++) begin
			j = {1'b0, 2'(i)} + use_n;
			buf_sh[i] = (j < 3'd4) ? buf_q[j[1:0]] : buf_q[i];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign status.kind     = kind;
	assign status.at_end   = last_q;
	assign status.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 3'd0;
			idx_q       <= 3'd0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q  <= cnt_q + 3'd1;
				last_q <= in_last;
			end else if (cmd.put_unit && unit_last) begin
				cnt_q <= cnt_q - use_n;
			end
			if (cmd.put_unit) begin
				idx_q <= unit_last ? 3'd0 : idx_q + 3'd1;
			end
			if (cmd.put_open || cmd.put_close || cmd.put_unit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= in_byte;
		end else if (cmd.put_unit && unit_last) begin
			for (int i = 0; i < 4; i++) begin
				buf_q[i] <= buf_sh[i];
			end
		end
		if (cmd.put_open || cmd.put_close) begin
			out_byte_q <= CH_QUOTE;
			out_last_q <= cmd.put_close;
		end else if (cmd.put_unit) begin
			out_byte_q <= unit_byte;
			out_last_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

@@ rtl/jsesc_ctrl.sv @@
// Controller: request acceptance, quote framing and drain sequencing.
module jsesc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  jsesc_pkg::dp_status_t status,
	output jsesc_pkg::dp_cmd_t    cmd
);
	import jsesc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_OPEN,
		S_DRAIN,
		S_CLOSE
	} state_t;

	state_t state_q;
	logic   inside_q;
	logic   has_work;
	logic   drain_done;

	assign has_work = (status.kind == HK_SINGLE) || (status.kind == HK_HEX)
		|| (status.kind == HK_PASS);
	assign drain_done = (status.kind == HK_EMPTY) || (status.kind == HK_HOLD);

	assign in_stall      = (state_q != S_IDLE);
	assign cmd.load      = (state_q == S_IDLE) && in_valid;
	assign cmd.put_open  = (state_q == S_OPEN) && status.out_free;
	assign cmd.put_unit  = (state_q == S_DRAIN) && status.out_free && has_work;
	assign cmd.put_close = (state_q == S_CLOSE) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			inside_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= inside_q ? S_DRAIN : S_OPEN;
					end
				end
				S_OPEN: begin
					if (status.out_free) begin
						inside_q <= 1'b1;
						state_q  <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drain_done) begin
						state_q <= status.at_end ? S_CLOSE : S_IDLE;
					end
				end
				S_CLOSE: begin
					if (status.out_free) begin
						inside_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/json_string_escaper_utf8_check.sv @@
// Top level of the JSON string escaper with UTF-8 validation.
// The input channel takes one raw string byte per request (in_byte, in_last);
// the output channel delivers the quoted, escaped JSON text one byte per
// request, with out_last marking the closing quote. Both channels use valid
// and stall, and a request moves when valid is high and stall is low.
// A request is taken only while the controller is idle; it is then decoded
// against up to three held bytes and its result bytes leave one per cycle
// while the receiver does not stall. The accepted byte is registered in the
// buffer, and each result byte passes through the single output register,
// which the sequencer fills one byte at a time; a request that only extends
// a held sequence yields no result bytes.
// Escapes yield six bytes per bad byte, so one request may yield up to 25.
// When the receiver stalls, the output register holds its byte and the whole
// sequencer waits, so in_stall stays high until the request is finished.
// Reset empties the held bytes, forgets any open string without a closing quote and clears out_valid.
module json_string_escaper_utf8_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import jsesc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	jsesc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	jsesc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

`ifndef ASSERT_OFF
	a_close_is_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |-> (out_byte == CH_QUOTE))
		else $error("closing byte is not a quote");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after accepting a request");

	a_idle_buffer_settled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (status.kind == HK_EMPTY || status.kind == HK_HOLD))
		else $error("idle with undrained bytes in the buffer");
`endif

endmodule
